>>> rtl/core/vce_pkg.sv
// Shared constants and types for the vibration command encoder.
package vce_pkg;

    localparam int LOW_FREQ    = 7;
    localparam int HIGH_FREQ   = 59;
    localparam int CYCLE_LIMIT = 255;
    localparam int TOP_POWER   = 7;

    localparam int NUM_FREQ     = HIGH_FREQ - LOW_FREQ + 1;
    localparam int FREQ_W       = 8;
    localparam int DUR_W        = 32;
    localparam int WORD_W       = 32;
    localparam int POW_W        = $clog2(TOP_POWER + 1);
    localparam int STEP_W       = POW_W;
    localparam int STEP_MS      = 2000;
    localparam int HALF_STEP_MS = 1000;
    localparam int LIMIT_NUM    = STEP_MS * (CYCLE_LIMIT + 1);
    localparam int LIM_W        = DUR_W + STEP_W;
    localparam int FP2_W        = FREQ_W + 1;
    localparam int NUM_W        = DUR_W + FP2_W;
    localparam int QUO_W        = 8;
    localparam int DIV_STAGES   = QUO_W / 2;
    localparam int DIV_W        = $clog2(STEP_MS * TOP_POWER + 1);
    localparam int REM_W        = DIV_W + QUO_W;

    localparam logic [7:0]        HEADER_BYTE = 8'h10;
    localparam logic [WORD_W-1:0] STOP_WORD   = 32'h1000_0000;
    localparam logic [3:0]        RAMP_FLAG   = 4'h8;

    typedef struct packed {
        logic              stop;
        logic [POW_W-1:0]  power;
        logic              up;
        logic              down;
        logic [FREQ_W-1:0] freq;
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic             neg;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } div_res_t;

endpackage

>>> rtl/core/vce_front.sv
// Request decode and frequency selection: two pipeline stages.
module vce_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 power_level,
    input  logic signed [7:0]          ramp_direction,
    input  logic [vce_pkg::FREQ_W-1:0] wanted_frequency,
    input  logic [vce_pkg::DUR_W-1:0]  duration_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output vce_pkg::cmd_t              out_cmd,
    output logic [vce_pkg::STEP_W-1:0] out_steps,
    output logic [vce_pkg::DUR_W-1:0]  out_dur
);
    import vce_pkg::*;

    logic [POW_W-1:0]    p_c;
    logic                up_c;
    logic                down_c;
    logic [STEP_W-1:0]   steps_c;
    logic [FREQ_W-1:0]   freq_c;
    logic [NUM_FREQ-1:0] hit_c;

    logic                a_valid_reg;
    cmd_t                a_cmd_reg;
    logic                a_auto_reg;
    logic [NUM_FREQ-1:0] a_hit_reg;
    logic [STEP_W-1:0]   a_steps_reg;
    logic [DUR_W-1:0]    a_dur_reg;

    logic                b_valid_reg;
    cmd_t                b_cmd_reg;
    logic [STEP_W-1:0]   b_steps_reg;
    logic [DUR_W-1:0]    b_dur_reg;

    logic                a_en;
    logic                b_en;
    logic [FREQ_W-1:0]   pick_c;
    cmd_t                b_cmd_next;

    assign b_en     = !b_valid_reg || !out_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign in_stall = !a_en;

    always_comb
    begin
        if (power_level > 8'(TOP_POWER))
        begin
            p_c = POW_W'(TOP_POWER);
        end
        else
        begin
            p_c = power_level[POW_W-1:0];
        end
        up_c   = (ramp_direction != 8'sd0) && !ramp_direction[7];
        down_c = ramp_direction[7];
        priority if (up_c)
        begin
            steps_c = STEP_W'(TOP_POWER + 1 - int'(p_c));
        end
        else if (down_c)
        begin
            steps_c = p_c;
        end
        else
        begin
            steps_c = STEP_W'(1);
        end
        priority if (wanted_frequency < FREQ_W'(LOW_FREQ))
        begin
            freq_c = FREQ_W'(LOW_FREQ);
        end
        else if (wanted_frequency > FREQ_W'(HIGH_FREQ))
        begin
            freq_c = FREQ_W'(HIGH_FREQ);
        end
        else
        begin
            freq_c = wanted_frequency;
        end
    end

    // duration limit per candidate frequency, scaled by step count
    for (genvar g = 0; g < NUM_FREQ; g++)
    begin : g_limit
        localparam int FREQ = LOW_FREQ + g;
        localparam int LIM  = LIMIT_NUM / (FREQ + 2);
        assign hit_c[g] = LIM_W'(duration_ms) <= LIM_W'(LIM) * LIM_W'(steps_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_cmd_reg.stop  <= (power_level == 8'd0) || (duration_ms == '0);
            a_cmd_reg.power <= p_c;
            a_cmd_reg.up    <= up_c;
            a_cmd_reg.down  <= down_c;
            a_cmd_reg.freq  <= freq_c;
            a_auto_reg      <= (wanted_frequency == '0);
            a_hit_reg       <= hit_c;
            a_steps_reg     <= steps_c;
            a_dur_reg       <= duration_ms;
        end
    end

    // highest passing frequency wins, lowest if none
    always_comb
    begin
        pick_c = FREQ_W'(LOW_FREQ);
        for (int g = 0; g < NUM_FREQ; g++)
        begin
            if (a_hit_reg[g])
            begin
                pick_c = FREQ_W'(LOW_FREQ + g);
            end
        end
        b_cmd_next = a_cmd_reg;
        if (a_auto_reg)
        begin
            b_cmd_next.freq = pick_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            b_cmd_reg   <= b_cmd_next;
            b_steps_reg <= a_steps_reg;
            b_dur_reg   <= a_dur_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_cmd   = b_cmd_reg;
    assign out_steps = b_steps_reg;
    assign out_dur   = b_dur_reg;

endmodule

>>> rtl/core/vce_cycles.sv
// Cycle count pipeline: product, bias and range check, radix-4 restoring division.
module vce_cycles
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  vce_pkg::cmd_t              in_cmd,
    input  logic [vce_pkg::STEP_W-1:0] in_steps,
    input  logic [vce_pkg::DUR_W-1:0]  in_dur,
    output logic                       out_valid,
    input  logic                       out_stall,
    output vce_pkg::div_res_t          out_res
);
    import vce_pkg::*;

    logic              s0_valid_reg;
    cmd_t              s0_cmd_reg;
    logic [STEP_W-1:0] s0_steps_reg;
    logic [NUM_W-1:0]  s0_num_reg;

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              s1_neg_reg;
    logic              s1_sat_reg;
    logic [REM_W-1:0]  s1_rem_reg;
    logic [DIV_W-1:0]  s1_div_reg;

    logic [DIV_STAGES-1:0] dv_valid_reg;
    cmd_t                  dv_cmd_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_neg_reg;
    logic [DIV_STAGES-1:0] dv_sat_reg;
    logic [REM_W-1:0]      dv_rem_reg [DIV_STAGES];
    logic [DIV_W-1:0]      dv_div_reg [DIV_STAGES];
    logic [QUO_W-1:0]      dv_quo_reg [DIV_STAGES];

    logic [DIV_STAGES:0]   ln_valid;
    cmd_t                  ln_cmd [DIV_STAGES+1];
    logic [DIV_STAGES:0]   ln_neg;
    logic [DIV_STAGES:0]   ln_sat;
    logic [REM_W-1:0]      ln_rem [DIV_STAGES+1];
    logic [DIV_W-1:0]      ln_div [DIV_STAGES+1];
    logic [QUO_W-1:0]      ln_quo [DIV_STAGES+1];

    logic [REM_W-1:0]      nx_rem [DIV_STAGES];
    logic [QUO_W-1:0]      nx_quo [DIV_STAGES];

    logic                  s0_en;
    logic                  s1_en;
    logic [DIV_STAGES-1:0] dv_en;

    logic [NUM_W-1:0]      bias_c;
    logic [NUM_W-1:0]      thr_c;
    logic [NUM_W-1:0]      diff_c;

    always_comb
    begin
        dv_en[DIV_STAGES-1] = !dv_valid_reg[DIV_STAGES-1] || !out_stall;
        for (int k = DIV_STAGES - 2; k >= 0; k--)
        begin
            dv_en[k] = !dv_valid_reg[k] || dv_en[k+1];
        end
        s1_en = !s1_valid_reg || dv_en[0];
        s0_en = !s0_valid_reg || s1_en;
    end

    assign in_stall = !s0_en;

    // bias is half a step period, saturation once the quotient reaches 2^QUO_W
    assign bias_c = NUM_W'(HALF_STEP_MS) * NUM_W'(s0_steps_reg);
    assign thr_c  = NUM_W'(STEP_MS * (1 << QUO_W)) * NUM_W'(s0_steps_reg);
    assign diff_c = s0_num_reg - bias_c;

    always_comb
    begin
        ln_valid[0] = s1_valid_reg;
        ln_cmd[0]   = s1_cmd_reg;
        ln_neg[0]   = s1_neg_reg;
        ln_sat[0]   = s1_sat_reg;
        ln_rem[0]   = s1_rem_reg;
        ln_div[0]   = s1_div_reg;
        ln_quo[0]   = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            ln_valid[k+1] = dv_valid_reg[k];
            ln_cmd[k+1]   = dv_cmd_reg[k];
            ln_neg[k+1]   = dv_neg_reg[k];
            ln_sat[k+1]   = dv_sat_reg[k];
            ln_rem[k+1]   = dv_rem_reg[k];
            ln_div[k+1]   = dv_div_reg[k];
            ln_quo[k+1]   = dv_quo_reg[k];
        end
    end

    // two quotient bits per stage, most significant first
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        localparam int HI = QUO_W - 1 - 2 * k;
        localparam int LO = HI - 1;
        logic [REM_W-1:0] sh_hi;
        logic [REM_W-1:0] sh_lo;
        logic [REM_W-1:0] r_mid;
        logic             ge_hi;
        logic             ge_lo;

        always_comb
        begin
            sh_hi = REM_W'(ln_div[k]) << HI;
            sh_lo = REM_W'(ln_div[k]) << LO;
            ge_hi = ln_rem[k] >= sh_hi;
            r_mid = ge_hi ? ln_rem[k] - sh_hi : ln_rem[k];
            ge_lo = r_mid >= sh_lo;
            nx_rem[k] = ge_lo ? r_mid - sh_lo : r_mid;
            nx_quo[k] = ln_quo[k];
            nx_quo[k][HI] = ge_hi;
            nx_quo[k][LO] = ge_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
        end
        else
        begin
            if (s0_en)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_en)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (dv_en[k])
                begin
                    dv_valid_reg[k] <= ln_valid[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_en)
        begin
            s0_cmd_reg   <= in_cmd;
            s0_steps_reg <= in_steps;
            s0_num_reg   <= NUM_W'(FP2_W'(in_cmd.freq) + FP2_W'(2)) * NUM_W'(in_dur);
        end
        if (s1_en)
        begin
            s1_cmd_reg <= s0_cmd_reg;
            s1_neg_reg <= s0_num_reg < bias_c;
            s1_sat_reg <= diff_c >= thr_c;
            s1_rem_reg <= diff_c[REM_W-1:0];
            s1_div_reg <= DIV_W'(STEP_MS) * DIV_W'(s0_steps_reg);
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (dv_en[k])
            begin
                dv_cmd_reg[k] <= ln_cmd[k];
                dv_neg_reg[k] <= ln_neg[k];
                dv_sat_reg[k] <= ln_sat[k];
                dv_rem_reg[k] <= nx_rem[k];
                dv_div_reg[k] <= ln_div[k];
                dv_quo_reg[k] <= nx_quo[k];
            end
        end
    end

    assign out_valid   = dv_valid_reg[DIV_STAGES-1];
    assign out_res.cmd = dv_cmd_reg[DIV_STAGES-1];
    assign out_res.neg = dv_neg_reg[DIV_STAGES-1];
    assign out_res.sat = dv_sat_reg[DIV_STAGES-1];
    assign out_res.quo = dv_quo_reg[DIV_STAGES-1];

endmodule

>>> rtl/core/vibration_command_encoder.sv
// Top level of the vibration command encoder: front end, cycle pipeline, output register.
// An accepted request passes through to its command word; one item per cycle unless cmd_stall backs the pipe up.
// There are nine register stages, each advancing whenever the next is free.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
module vibration_command_encoder
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [7:0]                 power_level,
    input  logic signed [7:0]          ramp_direction,
    input  logic [vce_pkg::FREQ_W-1:0] wanted_frequency,
    input  logic [vce_pkg::DUR_W-1:0]  duration_ms,
    output logic                       cmd_valid,
    input  logic                       cmd_stall,
    output logic [vce_pkg::WORD_W-1:0] command_word
);
    import vce_pkg::*;

    logic              fr_valid;
    logic              fr_stall;
    cmd_t              fr_cmd;
    logic [STEP_W-1:0] fr_steps;
    logic [DUR_W-1:0]  fr_dur;

    logic              cy_valid;
    logic              cy_stall;
    div_res_t          cy_res;

    logic              out_valid_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              out_en;
    logic [7:0]        count_c;
    logic [7:0]        pr_c;

    vce_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (req_valid),
        .in_stall         (req_stall),
        .power_level      (power_level),
        .ramp_direction   (ramp_direction),
        .wanted_frequency (wanted_frequency),
        .duration_ms      (duration_ms),
        .out_valid        (fr_valid),
        .out_stall        (fr_stall),
        .out_cmd          (fr_cmd),
        .out_steps        (fr_steps),
        .out_dur          (fr_dur)
    );

    vce_cycles u_cycles
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .in_cmd    (fr_cmd),
        .in_steps  (fr_steps),
        .in_dur    (fr_dur),
        .out_valid (cy_valid),
        .out_stall (cy_stall),
        .out_res   (cy_res)
    );

    assign out_en   = !out_valid_reg || !cmd_stall;
    assign cy_stall = !out_en;

    always_comb
    begin
        priority if (cy_res.neg)
        begin
            count_c = '0;
        end
        else if (cy_res.sat || (cy_res.quo > QUO_W'(CYCLE_LIMIT)))
        begin
            count_c = 8'(CYCLE_LIMIT);
        end
        else
        begin
            count_c = 8'(cy_res.quo);
        end
        priority if (cy_res.cmd.up)
        begin
            pr_c = {4'(cy_res.cmd.power), RAMP_FLAG};
        end
        else if (cy_res.cmd.down)
        begin
            pr_c = {RAMP_FLAG, 4'(cy_res.cmd.power)};
        end
        else
        begin
            pr_c = {4'(cy_res.cmd.power), 4'h0};
        end
        if (cy_res.cmd.stop)
        begin
            word_next = STOP_WORD;
        end
        else
        begin
            word_next = {HEADER_BYTE, pr_c, 8'(cy_res.cmd.freq), count_c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= cy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            word_reg <= word_next;
        end
    end

    assign cmd_valid    = out_valid_reg;
    assign command_word = word_reg;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the vibration command encoder.
`timescale 1ns / 100ps

module testbench;

    import vce_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AFTER  = 300;
    localparam int RANDOM_REQS    = 1450;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [7:0]        power;
        logic signed [7:0] ramp;
        logic [7:0]        freq;
        logic [31:0]       dur;
    } rumble_req_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [7:0]        power_level = '0;
    logic signed [7:0] ramp_direction = '0;
    logic [7:0]        wanted_frequency = '0;
    logic [31:0]       duration_ms = '0;
    logic              cmd_valid;
    logic              cmd_stall = 1'b0;
    logic [31:0]       command_word;

    rumble_req_t pending_reqs[$];
    logic [31:0] expected_words[$];

    int  mismatches = 0;
    int  words_seen = 0;
    int  idle_cycles = 0;
    int  cycle_num = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 0;
    bit  req_taken = 0;
    bit  word_taken = 0;

    vibration_command_encoder DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .power_level      (power_level),
        .ramp_direction   (ramp_direction),
        .wanted_frequency (wanted_frequency),
        .duration_ms      (duration_ms),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command_word     (command_word)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] encode_rumble(logic [7:0] power, logic signed [7:0] ramp,
                                                  logic [7:0] wanted, logic [31:0] dur);
        logic [3:0]        p;
        logic [7:0]        freq;
        logic [7:0]        pr_byte;
        bit                found;
        longint unsigned   steps;
        longint unsigned   lim;
        longint unsigned   num;
        longint unsigned   bias;
        longint unsigned   cycles;
        if (power == 0 || dur == 0)
            return STOP_WORD;
        p = (power > TOP_POWER) ? 4'(TOP_POWER) : power[3:0];
        if (ramp > 0)
            steps = TOP_POWER + 1 - p;
        else if (ramp < 0)
            steps = p;
        else
            steps = 1;

        if (wanted == 0) begin
            freq = 8'(LOW_FREQ);
            found = 0;
            for (int cand = HIGH_FREQ; cand >= LOW_FREQ; cand--)
            begin
                lim = longint'(LIMIT_NUM / (cand + 2)) * steps;
                if (!found && longint'(dur) <= lim)
                begin
                    freq = 8'(cand);
                    found = 1;
                end
            end
        end
        else if (wanted < LOW_FREQ)
            freq = 8'(LOW_FREQ);
        else if (wanted > HIGH_FREQ)
            freq = 8'(HIGH_FREQ);
        else
            freq = wanted;

        if (ramp > 0)
            pr_byte = {p, RAMP_FLAG};
        else if (ramp < 0)
            pr_byte = {RAMP_FLAG, p};
        else
            pr_byte = {p, 4'h0};

        num  = (longint'(freq) + 2) * longint'(dur);
        bias = HALF_STEP_MS * steps;
        if (num < bias)
            cycles = 0;
        else
            cycles = (num - bias) / (STEP_MS * steps);
        if (cycles > CYCLE_LIMIT)
            cycles = CYCLE_LIMIT;
        return {HEADER_BYTE, pr_byte, freq, cycles[7:0]};
    endfunction

    // mostly short gaps, a few long, none at all in periodic windows
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (cycle_num[8:7] == 2'b00)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_req(logic [7:0] power, logic signed [7:0] ramp,
                             logic [7:0] freq, logic [31:0] dur);
        rumble_req_t r;
        r.power = power;
        r.ramp  = ramp;
        r.freq  = freq;
        r.dur   = dur;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random_req();
        logic [7:0]        power;
        logic signed [7:0] ramp;
        logic [7:0]        freq;
        logic [31:0]       dur;
        int                r;
        int                f;
        r = $urandom_range(0, 99);
        if (r < 8)
            power = 8'd0;
        else if (r < 15)
            power = 8'($urandom_range(8, 255));
        else
            power = 8'($urandom_range(1, TOP_POWER));
        ramp = ($urandom_range(0, 4) == 0) ? 8'sd0 : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 40)
            freq = 8'd0;
        else if (r < 80)
            freq = 8'($urandom_range(LOW_FREQ, HIGH_FREQ));
        else
            freq = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 3)
            dur = 32'd0;
        else if (r < 33)
        begin
            // around a frequency's duration limit
            f = $urandom_range(LOW_FREQ, HIGH_FREQ);
            dur = 32'((LIMIT_NUM / (f + 2)) * $urandom_range(1, TOP_POWER)
                  + $urandom_range(0, 2) - 1);
        end
        else if (r < 73)
            dur = 32'($urandom_range(1, 600000));
        else if (r < 88)
            dur = 32'($urandom_range(1, 5000));
        else
            dur = 32'($urandom);
        queue_req(power, ramp, freq, dur);
    endtask

    initial
    begin
        queue_req(8'd0, 8'sd0, 8'd0, 32'd1000);
        queue_req(8'd5, 8'sd3, 8'd20, 32'd0);
        queue_req(8'd255, 8'sd0, 8'd30, 32'd50000);
        queue_req(8'd1, 8'sd127, 8'd7, 32'hFFFF_FFFF);
        queue_req(8'd7, -8'sd128, 8'd59, 32'd1);
        queue_req(8'd3, 8'sd0, 8'd0, 32'd8393);
        queue_req(8'd3, 8'sd0, 8'd0, 32'd8394);
        queue_req(8'd1, 8'sd1, 8'd0, 32'd58751);
        queue_req(8'd1, 8'sd1, 8'd0, 32'd58752);
        queue_req(8'd1, -8'sd5, 8'd0, 32'hFFFF_FFFF);
        queue_req(8'd6, -8'sd1, 8'd6, 32'd700);
        queue_req(8'd2, 8'sd0, 8'd60, 32'd12345);
        queue_req(8'd7, 8'sd0, 8'd255, 32'd30000);
        queue_req(8'h80, 8'sd64, 8'd1, 32'd2000);
        queue_req(8'd1, 8'sd0, 8'd8, 32'd100);
        queue_req(8'd1, 8'sd0, 8'd8, 32'd99);
        queue_req(8'd1, 8'sd0, 8'd8, 32'd51100);
        queue_req(8'd1, 8'sd0, 8'd8, 32'd51300);
        for (int p = 1; p <= TOP_POWER; p++)
            queue_req(8'(p), (p % 2) ? 8'sd2 : -8'sd2, 8'd0, 32'($urandom_range(1, 400000)));
        for (int i = 0; i < RANDOM_REQS; i++)
            queue_random_req();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // request driver
    always @(negedge clk)
    begin
        rumble_req_t r;
        if (rst_n && (!req_valid || req_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                r = pending_reqs.pop_front();
                power_level      <= r.power;
                ramp_direction   <= r.ramp;
                wanted_frequency <= r.freq;
                duration_ms      <= r.dur;
                req_valid        <= 1'b1;
                send_gap = pick_gap();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // command receiver, with one long hold-off to back the pipe up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                cmd_stall <= 1'b1;
            end
            else if (!holdoff_done && words_seen >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                cmd_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                cmd_stall <= 1'b1;
            end
            else
            begin
                cmd_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        logic [31:0] want;
        cycle_num++;
        if (rst_n)
        begin
            req_taken  = req_valid && (req_stall === 1'b0);
            word_taken = (cmd_valid === 1'b1) && !cmd_stall;
            if (req_taken)
                expected_words.push_back(encode_rumble(power_level, ramp_direction,
                                                       wanted_frequency, duration_ms));
            if (word_taken)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("command_word: expected none, actual %h", command_word);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (command_word !== want)
                    begin
                        $error("command_word: expected %h, actual %h", want, command_word);
                        mismatches++;
                    end
                end
            end
            idle_cycles = (req_taken || word_taken) ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

endmodule
